FILE: hdl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge while reset is released
`define NGLL_ASSERT_RUN(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("ngll assertion failed");

// property checked on every rising edge, reset included
`define NGLL_ASSERT_ANY(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("ngll assertion failed");

`endif

FILE: hdl/ngll_pkg.sv
// types and constants shared by the gll position extractor modules
`default_nettype none

package ngll_pkg;

    typedef logic [7:0] char_t;
    typedef logic [1:0] dir_t;

    // only the first bytes of a line are ever decoded
    localparam int DECODE_BYTES = 33;

    localparam char_t IDLE_BYTE  = 8'hFF;
    localparam char_t CR_BYTE    = 8'h0D;
    localparam char_t LF_BYTE    = 8'h0A;
    localparam char_t START_CHAR = 8'h24;
    localparam char_t COMMA_CHAR = 8'h2C;
    localparam char_t ZERO_CHAR  = 8'h30;
    localparam char_t NORTH_CHAR = 8'h4E;
    localparam char_t SOUTH_CHAR = 8'h53;
    localparam char_t EAST_CHAR  = 8'h45;
    localparam char_t WEST_CHAR  = 8'h57;

    localparam int          TAG_LEN  = 6;
    localparam logic [47:0] TAG_TEXT = "$GPGLL";

    // fixed field offsets within a line
    localparam int LAT_DEG_POS   = 7;
    localparam int LAT_MIN_POS   = 9;
    localparam int LAT_FRAC_POS  = 12;
    localparam int LAT_DIR_POS   = 18;
    localparam int LONG_DEG_POS  = 20;
    localparam int LONG_MIN_POS  = 23;
    localparam int LONG_FRAC_POS = 26;
    localparam int LONG_DIR_POS  = 32;

    localparam dir_t DIR_NONE   = 2'd0;
    localparam dir_t DIR_FIRST  = 2'd1;   // north or east
    localparam dir_t DIR_SECOND = 2'd2;   // south or west

    localparam logic [7:0] BAD_VALUE8  = 8'd255;
    localparam logic [9:0] BAD_VALUE10 = 10'd255;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // classified line end, element 0 is the most significant digit
    typedef struct packed {
        logic            found;
        dir_t            lat_dir;
        dir_t            lon_dir;
        char_t [1:0]     lat_deg_chars;
        char_t [1:0]     lat_min_chars;
        char_t [2:0]     lat_frac_chars;
        char_t [2:0]     long_deg_chars;
        char_t [1:0]     long_min_chars;
        char_t [2:0]     long_frac_chars;
    } ngll_req_t;

    typedef struct packed {
        logic       found;
        logic [7:0] lat_degrees;
        logic [7:0] lat_minutes;
        logic [9:0] lat_fraction;
        dir_t       lat_direction;
        logic [9:0] long_degrees;
        logic [7:0] long_minutes;
        logic [9:0] long_fraction;
        dir_t       long_direction;
    } ngll_res_t;

endpackage

`default_nettype wire

FILE: hdl/ngll_front.sv
// front end: byte capture, line store, line end detection and classification
`default_nettype none

module ngll_front
    import ngll_pkg::*;
#(
    parameter int LINE_BYTES = 64
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      take,
    input  wire char_t     rx_byte,
    output logic           push,
    output ngll_req_t      push_req
);

    localparam int WP_W = $clog2(LINE_BYTES + 1);

    char_t            store_reg [DECODE_BYTES];
    char_t            last_reg;
    logic [WP_W-1:0]  wp_reg;

    logic             active;
    logic [WP_W-1:0]  wp_eff;
    logic             do_store;
    logic             line_end;
    logic [WP_W-1:0]  wp_next;
    char_t            view [DECODE_BYTES];
    logic             tag_ok;

    assign active   = take && (rx_byte != IDLE_BYTE);
    assign wp_eff   = (rx_byte == START_CHAR) ? '0 : wp_reg;
    assign do_store = active && (wp_eff < WP_W'(LINE_BYTES));
    assign line_end = do_store && (rx_byte == LF_BYTE) && (wp_eff != '0)
                      && (last_reg == CR_BYTE);

    always_comb begin
        wp_next = wp_reg;
        if (do_store) begin
            wp_next = line_end ? '0 : WP_W'(wp_eff + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DECODE_BYTES; i++) begin
                store_reg[i] <= '0;
            end
            last_reg <= '0;
            wp_reg   <= '0;
        end else begin
            for (int i = 0; i < DECODE_BYTES; i++) begin
                if (do_store && (wp_eff == WP_W'(i))) begin
                    store_reg[i] <= rx_byte;
                end
            end
            if (do_store) begin
                last_reg <= rx_byte;
            end
            wp_reg <= wp_next;
        end
    end

    // store contents as they stand once the current byte is written
    always_comb begin
        for (int i = 0; i < DECODE_BYTES; i++) begin
            view[i] = (do_store && (wp_eff == WP_W'(i))) ? rx_byte : store_reg[i];
        end
    end

    always_comb begin
        tag_ok = 1'b1;
        for (int i = 0; i < TAG_LEN; i++) begin
            if (view[i] != TAG_TEXT[8*(TAG_LEN-1-i) +: 8]) begin
                tag_ok = 1'b0;
            end
        end
    end

    always_comb begin
        push_req       = '0;
        push_req.found = tag_ok && (view[LAT_DEG_POS] != COMMA_CHAR);
        if (push_req.found) begin
            if (view[LAT_DIR_POS] == NORTH_CHAR) begin
                push_req.lat_dir = DIR_FIRST;
            end else if (view[LAT_DIR_POS] == SOUTH_CHAR) begin
                push_req.lat_dir = DIR_SECOND;
            end else begin
                push_req.lat_dir = DIR_NONE;
            end
            if (view[LONG_DIR_POS] == EAST_CHAR) begin
                push_req.lon_dir = DIR_FIRST;
            end else if (view[LONG_DIR_POS] == WEST_CHAR) begin
                push_req.lon_dir = DIR_SECOND;
            end else begin
                push_req.lon_dir = DIR_NONE;
            end
        end
        for (int k = 0; k < 2; k++) begin
            push_req.lat_deg_chars[k]  = view[LAT_DEG_POS + k];
            push_req.lat_min_chars[k]  = view[LAT_MIN_POS + k];
            push_req.long_min_chars[k] = view[LONG_MIN_POS + k];
        end
        for (int k = 0; k < 3; k++) begin
            push_req.lat_frac_chars[k]  = view[LAT_FRAC_POS + k];
            push_req.long_deg_chars[k]  = view[LONG_DEG_POS + k];
            push_req.long_frac_chars[k] = view[LONG_FRAC_POS + k];
        end
    end

    assign push = line_end;

endmodule

`default_nettype wire

FILE: hdl/ngll_queue.sv
// two-entry request queue between front and back end
`default_nettype none

module ngll_queue
    import ngll_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire ngll_req_t push_req,
    output logic           has_room,
    input  wire logic      pop,
    output logic           head_valid,
    output ngll_req_t      head_req
);

    ngll_req_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_pop;

    assign has_room   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_req   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ngll_back.sv
// back end: digit arithmetic and result register
`default_nettype none

module ngll_back
    import ngll_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      head_valid,
    input  wire ngll_req_t head_req,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_ready,
    output ngll_res_t      out_res
);

    function automatic logic [7:0] two_digits(input char_t hi, input char_t lo);
        logic [7:0] d_hi;
        logic [7:0] d_lo;
        d_hi = hi - ZERO_CHAR;
        d_lo = lo - ZERO_CHAR;
        return 8'(d_hi * 8'd10 + d_lo);
    endfunction

    function automatic logic [9:0] three_digits(input char_t c0, input char_t c1,
                                                input char_t c2);
        logic [9:0] d0;
        logic [9:0] d1;
        logic [9:0] d2;
        d0 = {2'b00, c0} - {2'b00, ZERO_CHAR};
        d1 = {2'b00, c1} - {2'b00, ZERO_CHAR};
        d2 = {2'b00, c2} - {2'b00, ZERO_CHAR};
        return 10'(d0 * 10'd100 + d1 * 10'd10 + d2);
    endfunction

    logic       valid_reg;
    ngll_res_t  res_reg;
    ngll_res_t  res_next;

    assign pop = head_valid && (!valid_reg || out_ready);

    always_comb begin
        res_next = '0;
        if (head_req.found) begin
            res_next.found = 1'b1;
            if (head_req.lat_dir == DIR_NONE) begin
                res_next.lat_degrees  = BAD_VALUE8;
                res_next.lat_minutes  = BAD_VALUE8;
                res_next.lat_fraction = BAD_VALUE10;
            end else begin
                res_next.lat_degrees  = two_digits(head_req.lat_deg_chars[0],
                                                   head_req.lat_deg_chars[1]);
                res_next.lat_minutes  = two_digits(head_req.lat_min_chars[0],
                                                   head_req.lat_min_chars[1]);
                res_next.lat_fraction = three_digits(head_req.lat_frac_chars[0],
                                                     head_req.lat_frac_chars[1],
                                                     head_req.lat_frac_chars[2]);
            end
            res_next.lat_direction = head_req.lat_dir;
            if (head_req.lon_dir == DIR_NONE) begin
                res_next.long_degrees  = BAD_VALUE10;
                res_next.long_minutes  = BAD_VALUE8;
                res_next.long_fraction = BAD_VALUE10;
            end else begin
                res_next.long_degrees  = three_digits(head_req.long_deg_chars[0],
                                                      head_req.long_deg_chars[1],
                                                      head_req.long_deg_chars[2]);
                res_next.long_minutes  = two_digits(head_req.long_min_chars[0],
                                                    head_req.long_min_chars[1]);
                res_next.long_fraction = three_digits(head_req.long_frac_chars[0],
                                                      head_req.long_frac_chars[1],
                                                      head_req.long_frac_chars[2]);
            end
            res_next.long_direction = head_req.lon_dir;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

FILE: hdl/nmea_gll_position_extractor_unit.sv
// top level of the gll sentence position extractor
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   s_      | in        | s_valid / s_ready  | s_rx_byte, one receiver character
//   m_      | out       | m_valid / m_ready  | m_found, latitude and longitude
//
// one byte is taken every cycle while s_ready is high; the line end byte (lf after cr)
// is classified and written into the queue when it is accepted, the result register
// loads it from the queue head when it is empty or being read, and m_valid then rises
// synchronous reset clears the decoded part of the line store and the write position
// s_ready drops only while the two-entry queue holds two unread line ends
// a stalled m_ side keeps the result register and fills the queue
`default_nettype none

module nmea_gll_position_extractor_unit
    import ngll_pkg::*;
#(
    parameter int LINE_BYTES = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_found,
    output logic [7:0]      m_lat_degrees,
    output logic [7:0]      m_lat_minutes,
    output logic [9:0]      m_lat_fraction,
    output logic [1:0]      m_lat_direction,
    output logic [9:0]      m_long_degrees,
    output logic [7:0]      m_long_minutes,
    output logic [9:0]      m_long_fraction,
    output logic [1:0]      m_long_direction
);

    logic       take;
    logic       push;
    ngll_req_t  push_req;
    logic       has_room;
    logic       pop;
    logic       head_valid;
    ngll_req_t  head_req;
    ngll_res_t  out_res;

    // a request is taken whenever the queue can hold a possible line end
    assign s_ready = has_room;
    assign take    = s_valid && s_ready;

    // front end: line store, cr/lf tracking, tag and direction checks
    ngll_front #(
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .rx_byte  (s_rx_byte),
        .push     (push),
        .push_req (push_req)
    );

    // decouples byte capture from result delivery
    ngll_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_req   (push_req),
        .has_room   (has_room),
        .pop        (pop),
        .head_valid (head_valid),
        .head_req   (head_req)
    );

    // back end: digit sums and the output register
    ngll_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_req   (head_req),
        .pop        (pop),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_res    (out_res)
    );

    assign m_found          = out_res.found;
    assign m_lat_degrees    = out_res.lat_degrees;
    assign m_lat_minutes    = out_res.lat_minutes;
    assign m_lat_fraction   = out_res.lat_fraction;
    assign m_lat_direction  = out_res.lat_direction;
    assign m_long_degrees   = out_res.long_degrees;
    assign m_long_minutes   = out_res.long_minutes;
    assign m_long_fraction  = out_res.long_fraction;
    assign m_long_direction = out_res.long_direction;

endmodule

`default_nettype wire

FILE: hdl/ngll_checker.sv
// port-level assertions for the gll position extractor, with its bind
`default_nettype none

`include "assert_macros.svh"

module ngll_checker
    import ngll_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_found,
    input wire logic [7:0] m_lat_degrees,
    input wire logic [7:0] m_lat_minutes,
    input wire logic [9:0] m_lat_fraction,
    input wire logic [1:0] m_lat_direction,
    input wire logic [9:0] m_long_degrees,
    input wire logic [7:0] m_long_minutes,
    input wire logic [9:0] m_long_fraction,
    input wire logic [1:0] m_long_direction
);

    `NGLL_ASSERT_ANY(a_reset_clears_out, aclk, !aresetn |=> !m_valid)

    `NGLL_ASSERT_RUN(a_out_held, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_found)
            && $stable(m_lat_degrees) && $stable(m_long_degrees))

    `NGLL_ASSERT_RUN(a_not_found_zero, aclk, aresetn,
        m_valid && !m_found |-> m_lat_degrees == 8'd0 && m_lat_minutes == 8'd0
            && m_lat_fraction == 10'd0 && m_lat_direction == DIR_NONE
            && m_long_degrees == 10'd0 && m_long_minutes == 8'd0
            && m_long_fraction == 10'd0 && m_long_direction == DIR_NONE)

    `NGLL_ASSERT_RUN(a_bad_dir_marks, aclk, aresetn,
        m_valid && m_found && m_lat_direction == DIR_NONE |-> m_lat_degrees == BAD_VALUE8
            && m_lat_minutes == BAD_VALUE8 && m_lat_fraction == BAD_VALUE10)

endmodule

bind nmea_gll_position_extractor_unit ngll_checker u_ngll_checker (.*);

`default_nettype wire

FILE: sim/nmea_gll_position_extractor_unit_test.sv
// self-checking testbench for the gll sentence position extractor
module nmea_gll_position_extractor_unit_test;
    import ngll_pkg::*;

    localparam int STORE_BYTES  = 64;
    localparam int RANDOM_CHARS = 1100;
    localparam int STUCK_LIMIT  = 2000;

    // idling mix per phase, percent of cycles: none, sender, receiver, both
    localparam int PHASE_GAP   [4] = '{0, 47, 0, 23};
    localparam int PHASE_STALL [4] = '{0, 0, 47, 23};

    // results that can be read off without decoding any digits
    localparam ngll_res_t NO_FIX    = '0;
    localparam ngll_res_t BLIND_FIX = '{1'b1, BAD_VALUE8, BAD_VALUE8, BAD_VALUE10, DIR_NONE,
                                        BAD_VALUE10, BAD_VALUE8, BAD_VALUE10, DIR_NONE};

    // one row of directed stimulus: a character, how often it is sent, and
    // the line result typed in for the row that closes the line
    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] reps;
        logic       typed;
        ngll_res_t  fix;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 28;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // overflow: a run of cr fills the store and the rest is dropped,
        // so the lf that follows does not close a line
        '{START_CHAR, 8'd1,  1'b0, NO_FIX},
        '{CR_BYTE,    8'd70, 1'b0, NO_FIX},
        '{LF_BYTE,    8'd1,  1'b0, NO_FIX},
        // restart after overflow, empty latitude: not found
        '{START_CHAR, 8'd1,  1'b0, NO_FIX},
        '{"G",        8'd1,  1'b0, NO_FIX},
        '{"P",        8'd1,  1'b0, NO_FIX},
        '{"G",        8'd1,  1'b0, NO_FIX},
        '{"L",        8'd1,  1'b0, NO_FIX},
        '{"L",        8'd1,  1'b0, NO_FIX},
        '{COMMA_CHAR, 8'd2,  1'b0, NO_FIX},
        '{CR_BYTE,    8'd1,  1'b0, NO_FIX},
        '{LF_BYTE,    8'd1,  1'b1, NO_FIX},
        // short line, both direction offsets hold stale cr: both sides invalid
        '{START_CHAR, 8'd1,  1'b0, NO_FIX},
        '{"G",        8'd1,  1'b0, NO_FIX},
        '{"P",        8'd1,  1'b0, NO_FIX},
        '{"G",        8'd1,  1'b0, NO_FIX},
        '{"L",        8'd1,  1'b0, NO_FIX},
        '{"L",        8'd1,  1'b0, NO_FIX},
        '{COMMA_CHAR, 8'd1,  1'b0, NO_FIX},
        '{"1",        8'd1,  1'b0, NO_FIX},
        '{CR_BYTE,    8'd1,  1'b0, NO_FIX},
        '{LF_BYTE,    8'd1,  1'b1, BLIND_FIX},
        // lf at position zero with a cr in the last slot, byte extremes,
        // idle byte between cr and lf
        '{LF_BYTE,    8'd1,  1'b0, NO_FIX},
        '{8'h00,      8'd1,  1'b0, NO_FIX},
        '{8'hFE,      8'd1,  1'b0, NO_FIX},
        '{CR_BYTE,    8'd1,  1'b0, NO_FIX},
        '{IDLE_BYTE,  8'd1,  1'b0, NO_FIX},
        '{LF_BYTE,    8'd1,  1'b1, NO_FIX}
    };

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic       m_found;
    logic [7:0] m_lat_degrees;
    logic [7:0] m_lat_minutes;
    logic [9:0] m_lat_fraction;
    logic [1:0] m_lat_direction;
    logic [9:0] m_long_degrees;
    logic [7:0] m_long_minutes;
    logic [9:0] m_long_fraction;
    logic [1:0] m_long_direction;

    // shadow of the line store and its write position
    logic [7:0] line_copy [STORE_BYTES] = '{default: 8'h00};
    int         copy_pos = 0;

    // line results still owed by the block, oldest first
    ngll_res_t  pending_fixes [$];
    logic [7:0] line_text [$];

    // typed result for the request being driven, if any
    logic       fixed_on  = 1'b0;
    ngll_res_t  fixed_val = '0;

    int unsigned gap_pct         = 0;
    int unsigned stall_pct       = 0;
    int unsigned chars_sent      = 0;
    int unsigned idle_sent       = 0;
    int unsigned fixes_predicted = 0;
    int unsigned fixes_checked   = 0;
    int unsigned fixes_found     = 0;
    int unsigned fixes_bad_dir   = 0;
    int unsigned error_count     = 0;
    int unsigned stuck_cycles    = 0;

    nmea_gll_position_extractor_unit #(
        .LINE_BYTES(STORE_BYTES)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_found          (m_found),
        .m_lat_degrees    (m_lat_degrees),
        .m_lat_minutes    (m_lat_minutes),
        .m_lat_fraction   (m_lat_fraction),
        .m_lat_direction  (m_lat_direction),
        .m_long_degrees   (m_long_degrees),
        .m_long_minutes   (m_long_minutes),
        .m_long_fraction  (m_long_fraction),
        .m_long_direction (m_long_direction)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver back-pressure, changed on the falling edge only
    always @(negedge aclk) m_ready <= ($urandom_range(99) >= stall_pct);

    // ---------------------------------------------------------------
    // line decoder and character predictor
    // ---------------------------------------------------------------

    // weighted digit sum, each digit is the byte minus the zero character
    function automatic logic [31:0] digits_at(input int pos, input int count);
        logic [31:0] acc;
        acc = '0;
        for (int k = 0; k < count; k++)
            acc = acc * 32'd10 + ({24'd0, line_copy[pos + k]} - {24'd0, ZERO_CHAR});
        return acc;
    endfunction

    function automatic ngll_res_t decode_gll_line();
        ngll_res_t fix;
        logic      tag_ok;
        fix    = '0;
        tag_ok = 1'b1;
        for (int k = 0; k < TAG_LEN; k++)
            if (line_copy[k] != TAG_TEXT[8 * (TAG_LEN - 1 - k) +: 8]) tag_ok = 1'b0;
        // wrong talker or empty latitude: nothing but zeros
        if (!tag_ok || line_copy[LAT_DEG_POS] == COMMA_CHAR) return fix;
        fix.found          = 1'b1;
        fix.lat_degrees    = 8'(digits_at(LAT_DEG_POS, 2));
        fix.lat_minutes    = 8'(digits_at(LAT_MIN_POS, 2));
        fix.lat_fraction   = 10'(digits_at(LAT_FRAC_POS, 3));
        fix.long_degrees   = 10'(digits_at(LONG_DEG_POS, 3));
        fix.long_minutes   = 8'(digits_at(LONG_MIN_POS, 2));
        fix.long_fraction  = 10'(digits_at(LONG_FRAC_POS, 3));
        case (line_copy[LAT_DIR_POS])
            NORTH_CHAR: fix.lat_direction = DIR_FIRST;
            SOUTH_CHAR: fix.lat_direction = DIR_SECOND;
            default: begin
                fix.lat_degrees   = BAD_VALUE8;
                fix.lat_minutes   = BAD_VALUE8;
                fix.lat_fraction  = BAD_VALUE10;
                fix.lat_direction = DIR_NONE;
            end
        endcase
        case (line_copy[LONG_DIR_POS])
            EAST_CHAR: fix.long_direction = DIR_FIRST;
            WEST_CHAR: fix.long_direction = DIR_SECOND;
            default: begin
                fix.long_degrees   = BAD_VALUE10;
                fix.long_minutes   = BAD_VALUE8;
                fix.long_fraction  = BAD_VALUE10;
                fix.long_direction = DIR_NONE;
            end
        endcase
        return fix;
    endfunction

    // takes one accepted character, returns 1 when it closes a line
    function automatic logic absorb_char(input logic [7:0] ch, output ngll_res_t fix);
        logic line_end;
        fix = '0;
        if (ch == IDLE_BYTE) return 1'b0;
        if (ch == START_CHAR) copy_pos = 0;
        if (copy_pos >= STORE_BYTES) return 1'b0;
        line_copy[copy_pos] = ch;
        line_end = (ch == LF_BYTE) && (copy_pos > 0) && (line_copy[copy_pos - 1] == CR_BYTE);
        if (line_end) begin
            copy_pos = 0;
            fix      = decode_gll_line();
            return 1'b1;
        end
        copy_pos++;
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic flag_error(input string what);
        error_count++;
        $display("mismatch: %s", what);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("line result %0d, %s: got %0d, expected %0d",
                                 fixes_checked, name, got, want));
    endtask

    // everything is sampled on the rising edge: requests taken on s_ are
    // predicted first, then any result taken on m_ is checked against the
    // oldest prediction
    always @(posedge aclk) begin
        ngll_res_t fix;
        ngll_res_t seen;
        ngll_res_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (absorb_char(s_rx_byte, fix)) begin
                    pending_fixes.push_back(fixed_on ? fixed_val : fix);
                    fixes_predicted++;
                end
            end
            if (m_valid && m_ready) begin
                seen = {m_found, m_lat_degrees, m_lat_minutes, m_lat_fraction,
                        m_lat_direction, m_long_degrees, m_long_minutes,
                        m_long_fraction, m_long_direction};
                if (pending_fixes.size() == 0) begin
                    flag_error($sformatf("line result with none expected, found=%0d", m_found));
                end else begin
                    want = pending_fixes.pop_front();
                    compare_field("found",          seen.found,          want.found);
                    compare_field("lat_degrees",    seen.lat_degrees,    want.lat_degrees);
                    compare_field("lat_minutes",    seen.lat_minutes,    want.lat_minutes);
                    compare_field("lat_fraction",   seen.lat_fraction,   want.lat_fraction);
                    compare_field("lat_direction",  seen.lat_direction,  want.lat_direction);
                    compare_field("long_degrees",   seen.long_degrees,   want.long_degrees);
                    compare_field("long_minutes",   seen.long_minutes,   want.long_minutes);
                    compare_field("long_fraction",  seen.long_fraction,  want.long_fraction);
                    compare_field("long_direction", seen.long_direction, want.long_direction);
                    fixes_checked++;
                    if (want.found) fixes_found++;
                    if (want.found && (want.lat_direction == DIR_NONE ||
                                       want.long_direction == DIR_NONE)) fixes_bad_dir++;
                end
            end
            // watchdog: any request moving on either side clears it
            if ((s_valid && s_ready) || (m_valid && m_ready)) stuck_cycles = 0;
            else stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles, %0d results owed",
                         STUCK_LIMIT, pending_fixes.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    // presents one character on the falling edge and holds it until taken
    task automatic drive_char(input logic [7:0] ch, input logic typed, input ngll_res_t want);
        @(negedge aclk);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        fixed_on  = typed;
        fixed_val = want;
        s_valid   <= 1'b1;
        s_rx_byte <= ch;
        if (ch == IDLE_BYTE) idle_sent++;
        else chars_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic put_char(input logic [7:0] ch);
        drive_char(ch, 1'b0, NO_FIX);
    endtask

    // sender goes quiet until every owed line result has come out
    task automatic idle_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_fixes.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] printable_char();
        logic [7:0] c;
        c = 8'($urandom_range(126, 32));
        if (c == START_CHAR) c = "#";
        return c;
    endfunction

    function automatic void add_text(input string s);
        for (int k = 0; k < s.len(); k++) line_text.push_back(s[k]);
    endfunction

    // mostly decimal digits, now and then a stray character to make the sums wrap
    function automatic void add_digits(input int count);
        for (int k = 0; k < count; k++)
            line_text.push_back(($urandom_range(99) < 92) ?
                                ZERO_CHAR + 8'($urandom_range(9)) : printable_char());
    endfunction

    function automatic void add_direction(input logic [7:0] first, input logic [7:0] second);
        int unsigned pick;
        pick = $urandom_range(99);
        line_text.push_back(pick < 45 ? first : (pick < 90 ? second : printable_char()));
    endfunction

    task automatic send_random_line();
        int unsigned pick;
        int unsigned keep;
        line_text.delete();
        pick = $urandom_range(99);
        if (pick < 62) begin
            // well-formed gll sentence with random content
            add_text("$GPGLL,");
            if ($urandom_range(99) < 10) line_text[1 + $urandom_range(4)] = printable_char();
            if ($urandom_range(99) < 10) begin
                add_text(",");
            end else begin
                add_digits(4);
                add_text(".");
                add_digits(5);
                add_text(",");
                add_direction(NORTH_CHAR, SOUTH_CHAR);
                add_text(",");
                add_digits(5);
                add_text(".");
                add_digits(5);
                add_text(",");
                add_direction(EAST_CHAR, WEST_CHAR);
                add_text(",");
                add_digits(6);
                add_text(".");
                add_digits(2);
                add_text(",A*");
                add_digits(2);
            end
            // a cut line leaves the far offsets to stale bytes
            if ($urandom_range(99) < 20) begin
                keep = $urandom_range(line_text.size() - 1, 7);
                while (line_text.size() > keep) void'(line_text.pop_back());
            end
        end else if (pick < 72) begin
            // some other sentence
            if ($urandom_range(1) == 0) add_text("$GPGGA,");
            else add_text("$GPRMC,");
            repeat ($urandom_range(40)) line_text.push_back(printable_char());
        end else if (pick < 82) begin
            // raw noise, any byte value
            repeat ($urandom_range(24, 1)) line_text.push_back(8'($urandom_range(255)));
        end else if (pick < 90) begin
            // stray line-end characters
            repeat ($urandom_range(3)) line_text.push_back($urandom_range(1) ? CR_BYTE : LF_BYTE);
        end else begin
            // lines around and beyond the store size
            add_text("$GPGLL,");
            repeat ($urandom_range(90, 50)) line_text.push_back(printable_char());
        end
        // close the line, now and then with a character wedged between cr and lf
        line_text.push_back(CR_BYTE);
        if ($urandom_range(99) < 6) line_text.push_back(printable_char());
        line_text.push_back(LF_BYTE);
        foreach (line_text[k]) begin
            if ($urandom_range(99) < 4) put_char(IDLE_BYTE);
            put_char(line_text[k]);
        end
    endtask

    initial begin
        int unsigned random_base;
        int unsigned phase_end;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // directed rows first, no idling
        for (int r = 0; r < DIRECTED_ROWS; r++)
            for (int k = 0; k < int'(DIRECTED[r].reps); k++)
                drive_char(DIRECTED[r].ch, DIRECTED[r].typed, DIRECTED[r].fix);

        // random sentences under each idling mix, draining between phases
        random_base = chars_sent;
        for (int p = 0; p < 4; p++) begin
            gap_pct   = PHASE_GAP[p];
            stall_pct = PHASE_STALL[p];
            phase_end = random_base + RANDOM_CHARS * (p + 1) / 4;
            while (chars_sent < phase_end)
                send_random_line();
            idle_until_drained();
        end

        // allow for a late or spurious result to show up
        repeat (8) @(negedge aclk);

        $display("sent %0d characters and %0d idle bytes under four idling mixes",
                 chars_sent, idle_sent);
        $display("checked %0d line results: %0d with a position, %0d with a bad direction",
                 fixes_checked, fixes_found, fixes_bad_dir);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
